>>> rtl/block_dictionary_deframer_unit_defines.svh
// assertion macros for the block dictionary deframer
// used by the modules that carry concurrent checks; no other dependencies
`ifndef BLOCK_DICTIONARY_DEFRAMER_UNIT_DEFINES_SVH
`define BLOCK_DICTIONARY_DEFRAMER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define BDD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bdd assertion failed");
`define BDD_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bdd forbidden condition seen");
`else
`define BDD_ASSERT(lbl, clk, rst, prop)
`define BDD_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> rtl/bdd_pkg.sv
// shared types, codes and defaults of the block dictionary deframer
// no dependencies
`timescale 1ns / 1ps
package bdd_pkg;
   localparam int BDD_DICT_DEPTH = 65536;
   localparam int BDD_MAX_BLOCK  = 4096;

   localparam int HDR_DSIZE_POS  = 8;
   localparam int HDR_BCOUNT_POS = 12;
   localparam int HDR_LEN        = 16;
   localparam int BLKHDR_LEN     = 8;
   localparam int FLAGHDR_LEN    = 2;

   localparam logic [1:0] KIND_OK    = 2'd0;
   localparam logic [1:0] KIND_CSUM  = 2'd1;
   localparam logic [1:0] KIND_RANGE = 2'd2;
   localparam logic [1:0] KIND_FLAG  = 2'd3;

   typedef enum logic [2:0] {
      PH_HEADER, PH_BLK_HDR, PH_PAYLOAD, PH_FLAG_HDR, PH_FLAG_OFF, PH_DONE
   } parse_phase_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CHECK, ST_COPY, ST_STATUS,
      ST_FRD0, ST_FOUT0, ST_FRD1, ST_FOUT1
   } ctl_state_type;

   typedef struct packed {
      logic take;
      logic clr_run;
      logic copy_start;
      logic copy_run;
      logic rd_sel;
      logic load_status;
      logic load_flag;
      logic flag_last;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic blk_evt;
      logic flag_evt;
      logic copy_ok;
      logic copy_done;
      logic out_free;
   } status_type;
endpackage

>>> rtl/bdd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/bdd_ctrl.sv
// sequencing state machine of the deframer: clear, accept, copy, result beats
// depends on bdd_pkg
`timescale 1ns / 1ps
module bdd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bdd_pkg::status_type sts,
   output bdd_pkg::cmd_type    cmd
);
   import bdd_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.blk_evt) state_in = sts.copy_ok ? ST_COPY : ST_STATUS;
            else if (sts.flag_evt) state_in = ST_FRD0;
            else state_in = ST_IDLE;
         end
         ST_COPY:   if (sts.copy_done) state_in = ST_STATUS;
         ST_STATUS: if (sts.out_free) state_in = ST_IDLE;
         ST_FRD0:   state_in = ST_FOUT0;
         ST_FOUT0:  if (sts.out_free) state_in = ST_FRD1;
         ST_FRD1:   state_in = ST_FOUT1;
         ST_FOUT1:  if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_run = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take = req_valid;
         end
         ST_CHECK:  cmd.copy_start = sts.blk_evt & sts.copy_ok;
         ST_COPY:   cmd.copy_run = 1'b1;
         ST_STATUS: cmd.load_status = sts.out_free;
         ST_FRD0:   cmd.rd_sel = 1'b0;
         ST_FOUT0:  cmd.load_flag = sts.out_free;
         ST_FRD1:   cmd.rd_sel = 1'b1;
         ST_FOUT1: begin
            cmd.rd_sel = 1'b1;
            cmd.load_flag = sts.out_free;
            cmd.flag_last = 1'b1;
         end
         default: cmd = '0;
      endcase
   end
endmodule

>>> rtl/bdd_dpath.sv
// parser registers, staging and dictionary memories, copy engine, result register
// depends on bdd_pkg, bdd_ram and the assertion macro header
`timescale 1ns / 1ps
`include "block_dictionary_deframer_unit_defines.svh"
module bdd_dpath #(
   parameter int DICT_DEPTH = bdd_pkg::BDD_DICT_DEPTH,
   parameter int MAX_BLOCK  = bdd_pkg::BDD_MAX_BLOCK
) (
   input  logic                clock,
   input  logic                reset,
   input  bdd_pkg::cmd_type    cmd,
   output bdd_pkg::status_type sts,
   input  logic [7:0]          req_file_byte,
   input  logic                req_file_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [15:0]         rsp_block_number,
   output logic [7:0]          rsp_flag_byte,
   output logic                rsp_final_res
);
   import bdd_pkg::*;

   localparam int DAW = $clog2(DICT_DEPTH);
   localparam int SAW = $clog2(MAX_BLOCK);
   localparam int LW  = $clog2(MAX_BLOCK + 1);
   localparam logic [32:0] DEPTH_W = 33'(DICT_DEPTH);
   localparam logic [16:0] MAXB_W  = 17'(MAX_BLOCK);

   parse_phase_type phase_ff, phase_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] dsize_ff, dsize_in;
   logic [15:0] bdecl_ff, bdecl_in, bdone_ff, bdone_in;
   logic [31:0] boff_ff, boff_in;
   logic [15:0] bsum_ff, bsum_in, blen_ff, blen_in, rxor_ff, rxor_in;
   logic [7:0]  hold_ff, hold_in;
   logic [15:0] fdecl_ff, fdecl_in, fdone_ff, fdone_in;
   logic [31:0] facc_ff, facc_in;
   logic        blk_evt_ff, blk_evt_in, flag_evt_ff, flag_evt_in;
   logic        last_ff, last_in;
   logic [15:0] bnum_ff, bnum_in;
   logic        stg_we;

   logic [DAW-1:0] clr_addr_ff;
   logic [LW-1:0]  rd_idx_ff, wr_idx_ff;
   logic           wr_pend_ff;
   logic           rd_more;

   logic [32:0] limit, blk_end, rd_byte_addr;
   logic [1:0]  kind;
   logic [7:0]  stg_rd, dict_rd;
   logic        dict_we;
   logic [DAW-1:0] dict_wa;
   logic [7:0]  dict_wd;
   logic        rd_in_range_ff;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [15:0] rsp_bnum_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_final_ff;
   logic        out_free;

   // byte parser, restart applied before the byte is interpreted
   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; dsize_in = dsize_ff;
      bdecl_in = bdecl_ff; bdone_in = bdone_ff; boff_in = boff_ff;
      bsum_in = bsum_ff; blen_in = blen_ff; rxor_in = rxor_ff; hold_in = hold_ff;
      fdecl_in = fdecl_ff; fdone_in = fdone_ff; facc_in = facc_ff;
      blk_evt_in = 1'b0; flag_evt_in = 1'b0; last_in = last_ff; bnum_in = bnum_ff;
      stg_we = 1'b0;
      if (req_file_start) begin
         phase_in = PH_HEADER; pos_in = '0; dsize_in = '0; bdecl_in = '0;
         bdone_in = '0; boff_in = '0; bsum_in = '0; blen_in = '0; rxor_in = '0;
         hold_in = '0; fdecl_in = '0; fdone_in = '0; facc_in = '0;
      end
      unique case (phase_in)
         PH_HEADER: begin
            if (pos_in >= 16'(HDR_DSIZE_POS) && pos_in < 16'(HDR_DSIZE_POS + 4))
               dsize_in = {dsize_in[23:0], req_file_byte};
            else if (pos_in >= 16'(HDR_BCOUNT_POS) &&
                     pos_in < 16'(HDR_BCOUNT_POS + 2))
               bdecl_in = {bdecl_in[7:0], req_file_byte};
            if (pos_in >= 16'(HDR_LEN - 1)) begin
               phase_in = (bdecl_in == '0) ? PH_FLAG_HDR : PH_BLK_HDR;
               pos_in = '0;
            end else begin
               pos_in = pos_in + 16'd1;
            end
         end
         PH_BLK_HDR: begin
            if (pos_in < 16'd4)
               boff_in = (pos_in == '0) ? {24'd0, req_file_byte}
                                        : {boff_in[23:0], req_file_byte};
            else if (pos_in < 16'd6)
               bsum_in = (pos_in == 16'd4) ? {8'd0, req_file_byte}
                                           : {bsum_in[7:0], req_file_byte};
            else
               blen_in = (pos_in == 16'd6) ? {8'd0, req_file_byte}
                                           : {blen_in[7:0], req_file_byte};
            if (pos_in >= 16'(BLKHDR_LEN - 1)) begin
               rxor_in = '0; hold_in = '0; pos_in = '0;
               if (blen_in == '0) begin
                  blk_evt_in = 1'b1;
                  bnum_in = bdone_in;
                  bdone_in = bdone_in + 16'd1;
                  phase_in = (bdone_in == bdecl_in) ? PH_FLAG_HDR : PH_BLK_HDR;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               pos_in = pos_in + 16'd1;
            end
         end
         PH_PAYLOAD: begin
            stg_we = ({1'b0, pos_in} < MAXB_W);
            if (pos_in[0]) rxor_in = rxor_in ^ {hold_in, req_file_byte};
            else hold_in = req_file_byte;
            if ({1'b0, pos_in} + 17'd1 >= {1'b0, blen_in}) begin
               // odd length: last word padded with a zero low byte
               if (blen_in[0]) rxor_in = rxor_in ^ {hold_in, 8'd0};
               blk_evt_in = 1'b1;
               bnum_in = bdone_in;
               bdone_in = bdone_in + 16'd1;
               pos_in = '0;
               phase_in = (bdone_in == bdecl_in) ? PH_FLAG_HDR : PH_BLK_HDR;
            end else begin
               pos_in = pos_in + 16'd1;
            end
         end
         PH_FLAG_HDR: begin
            fdecl_in = (pos_in == '0) ? {8'd0, req_file_byte}
                                      : {fdecl_in[7:0], req_file_byte};
            if (pos_in >= 16'(FLAGHDR_LEN - 1)) begin
               pos_in = '0; fdone_in = '0;
               phase_in = (fdecl_in == '0) ? PH_DONE : PH_FLAG_OFF;
            end else begin
               pos_in = pos_in + 16'd1;
            end
         end
         PH_FLAG_OFF: begin
            facc_in = (pos_in == '0) ? {24'd0, req_file_byte}
                                     : {facc_in[23:0], req_file_byte};
            if (pos_in >= 16'd3) begin
               flag_evt_in = 1'b1;
               last_in = ({1'b0, fdone_in} + 17'd1 == {1'b0, fdecl_in});
               fdone_in = fdone_in + 16'd1;
               pos_in = '0;
               if (last_in) phase_in = PH_DONE;
            end else begin
               pos_in = pos_in + 16'd1;
            end
         end
         PH_DONE: phase_in = PH_DONE;
         default: phase_in = PH_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; pos_ff <= '0; dsize_ff <= '0; bdecl_ff <= '0;
         bdone_ff <= '0; boff_ff <= '0; bsum_ff <= '0; blen_ff <= '0;
         rxor_ff <= '0; hold_ff <= '0; fdecl_ff <= '0; fdone_ff <= '0;
         facc_ff <= '0; blk_evt_ff <= 1'b0; flag_evt_ff <= 1'b0;
         last_ff <= 1'b0; bnum_ff <= '0;
      end else if (cmd.take) begin
         phase_ff <= phase_in; pos_ff <= pos_in; dsize_ff <= dsize_in;
         bdecl_ff <= bdecl_in; bdone_ff <= bdone_in; boff_ff <= boff_in;
         bsum_ff <= bsum_in; blen_ff <= blen_in; rxor_ff <= rxor_in;
         hold_ff <= hold_in; fdecl_ff <= fdecl_in; fdone_ff <= fdone_in;
         facc_ff <= facc_in; blk_evt_ff <= blk_evt_in; flag_evt_ff <= flag_evt_in;
         last_ff <= last_in; bnum_ff <= bnum_in;
      end
   end

   // block verdict from the settled header and checksum
   assign limit   = ({1'b0, dsize_ff} > DEPTH_W) ? DEPTH_W : {1'b0, dsize_ff};
   assign blk_end = {1'b0, boff_ff} + {17'd0, blen_ff};
   always_comb begin
      if (rxor_ff != bsum_ff) kind = KIND_CSUM;
      else if ({1'b0, blen_ff} > MAXB_W || blk_end > limit) kind = KIND_RANGE;
      else kind = KIND_OK;
   end

   // copy engine: each registered staging read feeds its dictionary write in the next cycle
   assign rd_more = (17'(rd_idx_ff) != {1'b0, blen_ff});
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         rd_idx_ff <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         if (cmd.clr_run) clr_addr_ff <= clr_addr_ff + DAW'(1);
         if (cmd.copy_start) begin
            rd_idx_ff <= '0;
            wr_pend_ff <= 1'b0;
         end else if (cmd.copy_run) begin
            wr_pend_ff <= rd_more;
            if (rd_more) rd_idx_ff <= rd_idx_ff + LW'(1);
         end
      end
   end
   always_ff @(posedge clock) begin
      wr_idx_ff <= rd_idx_ff;
   end

   bdd_ram #(.WIDTH(8), .DEPTH(MAX_BLOCK)) u_stage (
      .clock   (clock),
      .wr_en   (cmd.take & stg_we),
      .wr_addr (pos_ff[SAW-1:0]),
      .wr_data (req_file_byte),
      .rd_addr (rd_idx_ff[SAW-1:0]),
      .rd_data (stg_rd)
   );

   always_comb begin
      if (cmd.clr_run) begin
         dict_we = 1'b1;
         dict_wa = clr_addr_ff;
         dict_wd = 8'd0;
      end else begin
         dict_we = wr_pend_ff & cmd.copy_run;
         dict_wa = boff_ff[DAW-1:0] + DAW'(wr_idx_ff);
         dict_wd = stg_rd;
      end
   end

   assign rd_byte_addr = {1'b0, facc_ff} + {32'd0, cmd.rd_sel};

   bdd_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_dict (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (dict_wa),
      .wr_data (dict_wd),
      .rd_addr (rd_byte_addr[DAW-1:0]),
      .rd_data (dict_rd)
   );

   always_ff @(posedge clock) begin
      rd_in_range_ff <= (rd_byte_addr < limit);
   end

   // result register
   assign out_free = ~rsp_valid_ff | rsp_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_status | cmd.load_flag) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         rsp_kind_ff  <= kind;
         rsp_bnum_ff  <= bnum_ff;
         rsp_byte_ff  <= 8'd0;
         rsp_final_ff <= 1'b0;
      end else if (cmd.load_flag) begin
         rsp_kind_ff  <= KIND_FLAG;
         rsp_bnum_ff  <= 16'd0;
         rsp_byte_ff  <= rd_in_range_ff ? dict_rd : 8'd0;
         rsp_final_ff <= cmd.flag_last & last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_block_number = rsp_bnum_ff;
   assign rsp_flag_byte    = rsp_byte_ff;
   assign rsp_final_res    = rsp_final_ff;

   assign sts.clear_done = (clr_addr_ff == DAW'(DICT_DEPTH - 1));
   assign sts.blk_evt    = blk_evt_ff;
   assign sts.flag_evt   = flag_evt_ff;
   assign sts.copy_ok    = (kind == KIND_OK) && (blen_ff != '0);
   assign sts.copy_done  = ~rd_more & ~wr_pend_ff;
   assign sts.out_free   = out_free;

   `BDD_ASSERT(a_load_when_free, clock, reset, (cmd.load_status | cmd.load_flag) |-> out_free)
   `BDD_NEVER(a_one_load, clock, reset, cmd.load_status & cmd.load_flag)
   `BDD_NEVER(a_no_copy_in_clear, clock, reset, cmd.clr_run & (cmd.copy_run | cmd.take))
   `BDD_ASSERT(a_copy_only_ok, clock, reset, cmd.copy_start |-> (kind == KIND_OK) && blk_evt_ff)
endmodule

>>> rtl/block_dictionary_deframer_unit.sv
// top level of the block dictionary deframer: controller plus datapath
// depends on bdd_pkg, bdd_ctrl, bdd_dpath, bdd_ram and the assertion macro header
//
//  channel   dir  ports                                   beat
//  req_      in   file_byte, file_start                   one file byte
//  rsp_      out  kind, block_number, flag_byte, final_res one status or flag byte
//
// each byte: accept in ST_IDLE, then a check in ST_CHECK before the next byte
// a block status adds ST_STATUS; a good block first copies through ST_COPY
// a flag entry adds FRD0, FOUT0, FRD1, FOUT1: two dictionary reads, one read port
// after reset the whole dictionary is cleared to zero before req_ready rises
// a held result stalls only bytes that produce a result
`timescale 1ns / 1ps
`include "block_dictionary_deframer_unit_defines.svh"
module block_dictionary_deframer_unit #(
   parameter int DICT_DEPTH = bdd_pkg::BDD_DICT_DEPTH,
   parameter int MAX_BLOCK  = bdd_pkg::BDD_MAX_BLOCK
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_file_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_block_number,
   output logic [7:0]  rsp_flag_byte,
   output logic        rsp_final_res
);
   import bdd_pkg::*;

   cmd_type    cmd;
   status_type sts;

   bdd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bdd_dpath #(.DICT_DEPTH(DICT_DEPTH), .MAX_BLOCK(MAX_BLOCK)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_file_byte    (req_file_byte),
      .req_file_start   (req_file_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_block_number (rsp_block_number),
      .rsp_flag_byte    (rsp_flag_byte),
      .rsp_final_res    (rsp_final_res)
   );

   `BDD_ASSERT(a_check_after_take, clock, reset, (req_valid & req_ready) |=> !req_ready)
   `BDD_ASSERT(a_final_is_flag, clock, reset, (rsp_valid & rsp_final_res) |-> rsp_kind == KIND_FLAG)
   `BDD_ASSERT(a_flag_no_block, clock, reset,
      (rsp_valid && rsp_kind == KIND_FLAG) |-> rsp_block_number == 16'd0)
endmodule
